[rtl/core/ctfc_pkg.sv]
`default_nettype none

package ctfc_pkg;

  // field and datapath widths
  localparam int unsigned OscW    = 26;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned NW      = 9;
  localparam int unsigned MW      = 6;
  localparam int unsigned DivW    = OscW + NW;   // full width of ref * N
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIntOsc = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgExtOsc = CfgIdxW'(1);

  // oscillator reset values
  localparam logic [OscW-1:0] IntOscReset = OscW'(16000000);
  localparam logic [OscW-1:0] ExtOscReset = OscW'(8000000);

  // system clock source codes
  localparam logic [1:0] SrcInt = 2'd0;
  localparam logic [1:0] SrcExt = 2'd1;
  localparam logic [1:0] SrcPll = 2'd2;

  // flash wait state thresholds and limits
  localparam logic [FreqW-1:0] Ws0Max     = FreqW'(30000000);
  localparam logic [FreqW-1:0] Ws1Max     = FreqW'(64000000);
  localparam logic [FreqW-1:0] Ws2Max     = FreqW'(90000000);
  localparam logic [FreqW-1:0] Ws3Max     = FreqW'(120000000);
  localparam logic [FreqW-1:0] Ws4Max     = FreqW'(150000000);
  localparam logic [FreqW-1:0] SysMax     = FreqW'(168000000);
  localparam logic [DivW-1:0]  VcoMin     = DivW'(100000000);
  localparam logic [DivW-1:0]  VcoMax     = DivW'(432000000);
  localparam logic [NW-1:0]    NMin       = NW'(2);
  localparam logic [NW-1:0]    NLimit     = NW'(433);
  localparam logic [2:0]       WsTooFast  = 3'd5;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StMSmall   = 3'd1,
    StNRange   = 3'd2,
    StVcoRange = 3'd3,
    StTooFast  = 3'd4
  } status_e;

  // request fields that ride along with the divider
  typedef struct packed {
    logic [1:0]    src;
    logic [3:0]    ahb;
    logic [2:0]    apb1;
    logic [2:0]    apb2;
    logic [NW-1:0] n;
    logic [MW-1:0] m;
    logic [1:0]    pcode;
  } side_t;

  // one divider cell's contents: dividend bits shift out at the top while
  // quotient bits shift in at the bottom
  typedef struct packed {
    logic [DivW-1:0] word;
    logic [MW-1:0]   rem;
    side_t           side;
  } div_t;

  // divide by zero is taken as divide by one
  function automatic logic [MW-1:0] divisor_of(input logic [MW-1:0] m);
    divisor_of = (m == '0) ? MW'(1) : m;
  endfunction

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    if (!code[3]) begin
      sh = 4'd0;
    end else if (!code[2]) begin
      sh = 4'd1 + {2'b00, code[1:0]};
    end else begin
      sh = 4'd6 + {2'b00, code[1:0]};
    end
    ahb_shift = sh;
  endfunction

  function automatic logic [3:0] apb_shift(input logic [2:0] code);
    apb_shift = code[2] ? (4'd1 + {2'b00, code[1:0]}) : 4'd0;
  endfunction

  // rounded divide by a power of two; result always fits 32 bits
  function automatic logic [FreqW-1:0] bus_div(input logic [FreqW-1:0] sys,
                                               input logic [3:0] sh);
    logic [FreqW:0] half;
    logic [FreqW:0] sum;
    half = (sh == 4'd0) ? '0 : ((FreqW+1)'(1) << (sh - 4'd1));
    sum  = {1'b0, sys} + half;
    bus_div = FreqW'(sum >> sh);
  endfunction

  function automatic logic [FreqW-1:0] sat32(input logic [DivW:0] x);
    sat32 = (|x[DivW:FreqW]) ? '1 : x[FreqW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/ctfc_div_cell.sv]
`default_nettype none

module ctfc_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire ctfc_pkg::div_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output ctfc_pkg::div_t      data_o
);
  import ctfc_pkg::*;

  logic          valid_q;
  div_t          data_q;
  div_t          data_d;
  logic [MW:0]   partial;
  logic [MW:0]   dvs;
  logic          ge;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    dvs     = {1'b0, divisor_of(data_i.side.m)};
    partial = {data_i.rem, data_i.word[DivW-1]};
    ge      = (partial >= dvs);
    data_d      = data_i;
    data_d.rem  = ge ? MW'(partial - dvs) : MW'(partial);
    data_d.word = {data_i.word[DivW-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, data_q.rem} < {1'b0, divisor_of(data_q.side.m)}))
    else $error("divider cell remainder not below divisor");

  // a held request leaves only when the next cell takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q)
    else $error("divider cell dropped a request");

  // a taken request shows up in the cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid_q)
    else $error("divider cell lost an accepted request");

endmodule

`default_nettype wire

[rtl/core/clock_tree_frequency_calculator_core.sv]
`default_nettype none

// Clock tree frequency calculator. Each request (one snapshot of clock
// control fields) yields one result: VCO, system, AHB and both APB
// frequencies with round-to-nearest division, flash wait states and a status
// code. A new request is taken every cycle while the output is not stalled.
// A request passes the ref * N multiply register, then the divide by M, which
// runs through a row of 35 cells that each settle one quotient bit, then the
// system clock and bus clock registers. Empty slots in the row close up while
// the output is stalled. Oscillator registers are written through the cfg
// port while no request is in flight; the user must keep to this, not the block.
module clock_tree_frequency_calculator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [ctfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ctfc_pkg::OscW-1:0]    cfg_wdata_i,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   sys_source_i,
  input  wire logic [3:0]                   ahb_div_code_i,
  input  wire logic [2:0]                   apb1_div_code_i,
  input  wire logic [2:0]                   apb2_div_code_i,
  input  wire logic                         pll_input_sel_i,
  input  wire logic [8:0]                   pll_mult_n_i,
  input  wire logic [5:0]                   pll_div_m_i,
  input  wire logic [1:0]                   pll_div_p_code_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [31:0]                       vco_hz_o,
  output logic [31:0]                       sysclk_hz_o,
  output logic [31:0]                       hclk_hz_o,
  output logic [31:0]                       pclk1_hz_o,
  output logic [31:0]                       pclk2_hz_o,
  output logic [2:0]                        flash_wait_states_o,
  output logic [2:0]                        status_o
);
  import ctfc_pkg::*;

  logic [OscW-1:0] int_osc_q;
  logic [OscW-1:0] ext_osc_q;

  // oscillator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_osc_q <= IntOscReset;
      ext_osc_q <= ExtOscReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIntOsc: int_osc_q <= cfg_wdata_i;
        CfgExtOsc: ext_osc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ready chain, from the output back to the input
  logic rdy_b;
  logic rdy_a;
  logic rdy_0;
  logic v0_q;
  logic va_q;
  logic vb_q;

  logic [DivW:0] chain_valid;
  logic [DivW:0] chain_ready;
  div_t          chain_data [0:DivW];

  assign rdy_b      = !vb_q || !out_stall_i;
  assign rdy_a      = !va_q || rdy_b;
  assign rdy_0      = !v0_q || chain_ready[0];
  assign in_stall_o = !rdy_0;

  // multiply stage: ref * N plus the rounding offset M/2
  logic [OscW-1:0] ref_osc;
  logic [DivW-1:0] dividend;
  div_t            s0_d;
  div_t            s0_q;

  always_comb begin
    ref_osc  = pll_input_sel_i ? ext_osc_q : int_osc_q;
    dividend = DivW'(ref_osc) * DivW'(pll_mult_n_i)
             + DivW'(pll_div_m_i >> 1);
    s0_d.word       = dividend;
    s0_d.rem        = '0;
    s0_d.side.src   = sys_source_i;
    s0_d.side.ahb   = ahb_div_code_i;
    s0_d.side.apb1  = apb1_div_code_i;
    s0_d.side.apb2  = apb2_div_code_i;
    s0_d.side.n     = pll_mult_n_i;
    s0_d.side.m     = pll_div_m_i;
    s0_d.side.pcode = pll_div_p_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy_0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_0) begin
      s0_q <= s0_d;
    end
  end

  assign chain_valid[0] = v0_q;
  assign chain_data[0]  = s0_q;

  // divide by M, one quotient bit per cell
  for (genvar k = 0; k < DivW; k++) begin : g_cell
    ctfc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign chain_ready[DivW] = rdy_a;

  // system clock stage: PLL output, source select, wait states, status
  side_t           side_c;
  logic [DivW-1:0] vco;
  logic [2:0]      p_sh;
  logic [DivW:0]   pll_sum;
  logic [DivW:0]   pll;
  logic [FreqW-1:0] sys_a;
  logic [2:0]      ws_a;
  status_e         st_a;
  logic            is_pll;

  always_comb begin
    side_c  = chain_data[DivW].side;
    vco     = chain_data[DivW].word;
    p_sh    = {1'b0, side_c.pcode} + 3'd1;
    pll_sum = {1'b0, vco} + ((DivW+1)'(1) << side_c.pcode);
    pll     = pll_sum >> p_sh;
    is_pll  = (side_c.src == SrcPll);

    case (side_c.src)
      SrcInt:  sys_a = FreqW'(int_osc_q);
      SrcExt:  sys_a = FreqW'(ext_osc_q);
      SrcPll:  sys_a = sat32(pll);
      default: sys_a = '0;
    endcase

    if (sys_a <= Ws0Max) begin
      ws_a = 3'd0;
    end else if (sys_a <= Ws1Max) begin
      ws_a = 3'd1;
    end else if (sys_a <= Ws2Max) begin
      ws_a = 3'd2;
    end else if (sys_a <= Ws3Max) begin
      ws_a = 3'd3;
    end else if (sys_a <= Ws4Max) begin
      ws_a = 3'd4;
    end else begin
      ws_a = WsTooFast;
    end

    if (is_pll && (side_c.n < NMin || side_c.n >= NLimit)) begin
      st_a = StNRange;
    end else if (is_pll && side_c.m <= MW'(1)) begin
      st_a = StMSmall;
    end else if (is_pll && (vco < VcoMin || vco > VcoMax)) begin
      st_a = StVcoRange;
    end else if (sys_a > SysMax) begin
      st_a = StTooFast;
    end else begin
      st_a = StOk;
    end
  end

  logic [FreqW-1:0] vco_a_q;
  logic [FreqW-1:0] sys_a_q;
  logic [2:0]       ws_a_q;
  status_e          st_a_q;
  logic [3:0]       ahb_a_q;
  logic [2:0]       apb1_a_q;
  logic [2:0]       apb2_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= chain_valid[DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[DivW] && rdy_a) begin
      vco_a_q  <= sat32({1'b0, vco});
      sys_a_q  <= sys_a;
      ws_a_q   <= ws_a;
      st_a_q   <= st_a;
      ahb_a_q  <= side_c.ahb;
      apb1_a_q <= side_c.apb1;
      apb2_a_q <= side_c.apb2;
    end
  end

  // bus clock stage and output register
  logic [FreqW-1:0] vco_b_q;
  logic [FreqW-1:0] sys_b_q;
  logic [FreqW-1:0] hclk_b_q;
  logic [FreqW-1:0] pclk1_b_q;
  logic [FreqW-1:0] pclk2_b_q;
  logic [2:0]       ws_b_q;
  status_e          st_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q && rdy_b) begin
      vco_b_q   <= vco_a_q;
      sys_b_q   <= sys_a_q;
      hclk_b_q  <= bus_div(sys_a_q, ahb_shift(ahb_a_q));
      pclk1_b_q <= bus_div(sys_a_q, apb_shift(apb1_a_q));
      pclk2_b_q <= bus_div(sys_a_q, apb_shift(apb2_a_q));
      ws_b_q    <= ws_a_q;
      st_b_q    <= st_a_q;
    end
  end

  assign out_valid_o         = vb_q;
  assign vco_hz_o            = vco_b_q;
  assign sysclk_hz_o         = sys_b_q;
  assign hclk_hz_o           = hclk_b_q;
  assign pclk1_hz_o          = pclk1_b_q;
  assign pclk2_hz_o          = pclk2_b_q;
  assign flash_wait_states_o = ws_b_q;
  assign status_o            = st_b_q;

  // too fast always comes with the top wait state count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StTooFast) |-> (flash_wait_states_o == WsTooFast))
    else $error("too fast status without top wait states");

  // a stopped system clock needs no wait states and is never too fast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sysclk_hz_o == '0) |->
      (flash_wait_states_o == 3'd0 && status_o != StTooFast))
    else $error("zero system clock with wait states or too fast status");

  // bus clocks never exceed the system clock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hclk_hz_o <= sysclk_hz_o && pclk1_hz_o <= sysclk_hz_o
                     && pclk2_hz_o <= sysclk_hz_o))
    else $error("bus clock above system clock");

endmodule

`default_nettype wire

[test/clock_tree_frequency_calculator_core_tb.sv]
`default_nettype none

module clock_tree_frequency_calculator_core_tb;
  import ctfc_pkg::*;

  // register indexes that hold no register
  localparam logic [CfgIdxW-1:0] CfgNoReg2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgNoReg3 = CfgIdxW'(3);
  // reserved system clock source
  localparam logic [1:0] SrcRsv = 2'd3;

  localparam int NumDirected = 22;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 68;
  localparam int LongHold    = 150;
  localparam int Settle      = 45;

  // one request: a snapshot of the clock control fields
  typedef struct packed {
    logic [1:0] src;
    logic [3:0] ahb;
    logic [2:0] apb1;
    logic [2:0] apb2;
    logic       psel;
    logic [8:0] n;
    logic [5:0] m;
    logic [1:0] pcode;
  } snap_t;

  // one result: the derived clock tree
  typedef struct packed {
    logic [31:0] vco;
    logic [31:0] sys;
    logic [31:0] hclk;
    logic [31:0] pclk1;
    logic [31:0] pclk2;
    logic [2:0]  ws;
    status_e     st;
  } clocks_t;

  typedef struct packed {
    snap_t   snap;
    logic    known;
    clocks_t clk;
  } dir_row_t;

  typedef struct packed {
    logic [OscW-1:0] int_hz;
    logic [OscW-1:0] ext_hz;
    logic            rnd;
    logic            tx_idle;
    logic            rx_idle;
    logic            hold;
    logic            pause;
  } phase_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [OscW-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        sys_source_i;
  logic [3:0]        ahb_div_code_i;
  logic [2:0]        apb1_div_code_i;
  logic [2:0]        apb2_div_code_i;
  logic              pll_input_sel_i;
  logic [8:0]        pll_mult_n_i;
  logic [5:0]        pll_div_m_i;
  logic [1:0]        pll_div_p_code_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [31:0]       vco_hz_o;
  logic [31:0]       sysclk_hz_o;
  logic [31:0]       hclk_hz_o;
  logic [31:0]       pclk1_hz_o;
  logic [31:0]       pclk2_hz_o;
  logic [2:0]        flash_wait_states_o;
  logic [2:0]        status_o;

  // oscillator settings as the block should hold them
  logic [OscW-1:0] int_osc;
  logic [OscW-1:0] ext_osc;

  clocks_t pending_clocks [$];
  int unsigned mismatches = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic long_hold  = 1'b0;

  // directed requests; expectations typed in only where obvious
  dir_row_t directed_rows [NumDirected] = '{
    '{'{SrcInt, 4'd0, 3'd0, 3'd0, 1'b0, 9'd0, 6'd0, 2'd0}, 1'b1,
      '{32'd0, 32'd16000000, 32'd16000000, 32'd16000000, 32'd16000000, 3'd0, StOk}},
    '{'{SrcExt, 4'd0, 3'd0, 3'd0, 1'b1, 9'd0, 6'd0, 2'd0}, 1'b1,
      '{32'd0, 32'd8000000, 32'd8000000, 32'd8000000, 32'd8000000, 3'd0, StOk}},
    '{'{SrcRsv, 4'd15, 3'd7, 3'd7, 1'b1, 9'd511, 6'd63, 2'd3}, 1'b1,
      '{32'd64888889, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, StOk}},
    '{'{SrcPll, 4'd0, 3'd5, 3'd4, 1'b0, 9'd336, 6'd16, 2'd0}, 1'b1,
      '{32'd336000000, 32'd168000000, 32'd168000000, 32'd42000000, 32'd84000000,
        3'd5, StOk}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b0, 9'd1, 6'd16, 2'd0}, 1'b1,
      '{32'd1000000, 32'd500000, 32'd500000, 32'd500000, 32'd500000, 3'd0, StNRange}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b0, 9'd433, 6'd0, 2'd0}, 1'b1,
      '{32'hFFFFFFFF, 32'd3464000000, 32'd3464000000, 32'd3464000000, 32'd3464000000,
        3'd5, StNRange}},
    '{'{SrcPll, 4'd8, 3'd7, 3'd6, 1'b0, 9'd100, 6'd1, 2'd3}, 1'b1,
      '{32'd1600000000, 32'd100000000, 32'd50000000, 32'd6250000, 32'd12500000,
        3'd3, StMSmall}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b1, 9'd99, 6'd8, 2'd0}, 1'b1,
      '{32'd99000000, 32'd49500000, 32'd49500000, 32'd49500000, 32'd49500000,
        3'd1, StVcoRange}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b1, 9'd100, 6'd8, 2'd1}, 1'b1,
      '{32'd100000000, 32'd25000000, 32'd25000000, 32'd25000000, 32'd25000000,
        3'd0, StOk}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b1, 9'd432, 6'd8, 2'd0}, 1'b1,
      '{32'd432000000, 32'd216000000, 32'd216000000, 32'd216000000, 32'd216000000,
        3'd5, StTooFast}},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b0, 9'd406, 6'd15, 2'd3}, 1'b0, '0},
    '{'{SrcInt, 4'd0, 3'd0, 3'd0, 1'b0, 9'd511, 6'd1, 2'd0}, 1'b1,
      '{32'hFFFFFFFF, 32'd16000000, 32'd16000000, 32'd16000000, 32'd16000000,
        3'd0, StOk}},
    '{'{SrcPll, 4'd9, 3'd4, 3'd5, 1'b1, 9'd200, 6'd3, 2'd2}, 1'b0, '0},
    '{'{SrcPll, 4'd10, 3'd6, 3'd7, 1'b0, 9'd255, 6'd7, 2'd1}, 1'b0, '0},
    '{'{SrcPll, 4'd11, 3'd1, 3'd2, 1'b1, 9'd300, 6'd5, 2'd3}, 1'b0, '0},
    '{'{SrcPll, 4'd12, 3'd3, 3'd4, 1'b0, 9'd432, 6'd63, 2'd0}, 1'b0, '0},
    '{'{SrcPll, 4'd13, 3'd5, 3'd6, 1'b1, 9'd2, 6'd2, 2'd1}, 1'b0, '0},
    '{'{SrcInt, 4'd14, 3'd7, 3'd4, 1'b0, 9'd50, 6'd3, 2'd2}, 1'b0, '0},
    '{'{SrcExt, 4'd15, 3'd6, 3'd5, 1'b1, 9'd77, 6'd9, 2'd3}, 1'b0, '0},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b0, 9'd0, 6'd0, 2'd0}, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, StNRange}},
    '{'{SrcPll, 4'd8, 3'd0, 3'd0, 1'b1, 9'd511, 6'd0, 2'd3}, 1'b0, '0},
    '{'{SrcPll, 4'd0, 3'd0, 3'd0, 1'b0, 9'd21, 6'd0, 2'd0}, 1'b1,
      '{32'd336000000, 32'd168000000, 32'd168000000, 32'd168000000, 32'd168000000,
        3'd5, StMSmall}}
  };

  // oscillator settings per phase, extremes and threshold edges among them
  phase_t phase_plan [NumPhases] = '{
    '{26'd16000000, 26'd8000000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{26'd0, 26'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
    '{26'd50000000, 26'd25000000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{26'h3FFFFFF, 26'h3FFFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{26'd30000000, 26'd30000001, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{26'd64000001, 26'd64000000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{26'd0, 26'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{26'd0, 26'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  clock_tree_frequency_calculator_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sys_source_i        (sys_source_i),
    .ahb_div_code_i      (ahb_div_code_i),
    .apb1_div_code_i     (apb1_div_code_i),
    .apb2_div_code_i     (apb2_div_code_i),
    .pll_input_sel_i     (pll_input_sel_i),
    .pll_mult_n_i        (pll_mult_n_i),
    .pll_div_m_i         (pll_div_m_i),
    .pll_div_p_code_i    (pll_div_p_code_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .vco_hz_o            (vco_hz_o),
    .sysclk_hz_o         (sysclk_hz_o),
    .hclk_hz_o           (hclk_hz_o),
    .pclk1_hz_o          (pclk1_hz_o),
    .pclk2_hz_o          (pclk2_hz_o),
    .flash_wait_states_o (flash_wait_states_o),
    .status_o            (status_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // round to nearest, divide by zero taken as divide by one
  function automatic logic [63:0] round_div(input logic [63:0] x, input logic [63:0] d);
    logic [63:0] dd;
    dd = (d == 64'd0) ? 64'd1 : d;
    return (x + dd / 64'd2) / dd;
  endfunction

  function automatic logic [31:0] clamp32(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // expected clock tree for one snapshot under the current oscillator settings
  function automatic clocks_t calc_clock_tree(input snap_t s);
    logic [63:0] ref_hz;
    logic [63:0] vco;
    logic [63:0] sys;
    logic [63:0] ahb_d;
    logic [63:0] apb1_d;
    logic [63:0] apb2_d;
    clocks_t c;
    ref_hz = s.psel ? 64'(ext_osc) : 64'(int_osc);
    vco = round_div(ref_hz * 64'(s.n), 64'(s.m));
    case (s.src)
      SrcInt:  sys = 64'(int_osc);
      SrcExt:  sys = 64'(ext_osc);
      SrcPll:  sys = 64'(clamp32(round_div(vco, 64'd2 << s.pcode)));
      default: sys = 64'd0;
    endcase
    ahb_d  = !s.ahb[3] ? 64'd1 : (!s.ahb[2] ? (64'd2 << s.ahb[1:0]) : (64'd64 << s.ahb[1:0]));
    apb1_d = s.apb1[2] ? (64'd2 << s.apb1[1:0]) : 64'd1;
    apb2_d = s.apb2[2] ? (64'd2 << s.apb2[1:0]) : 64'd1;
    // flash wait states from the system clock
    if (sys <= 64'(Ws0Max)) c.ws = 3'd0;
    else if (sys <= 64'(Ws1Max)) c.ws = 3'd1;
    else if (sys <= 64'(Ws2Max)) c.ws = 3'd2;
    else if (sys <= 64'(Ws3Max)) c.ws = 3'd3;
    else if (sys <= 64'(Ws4Max)) c.ws = 3'd4;
    else c.ws = WsTooFast;
    // first fault wins; pll checks only when the pll drives the system clock
    if (s.src == SrcPll && (s.n < NMin || s.n >= NLimit)) c.st = StNRange;
    else if (s.src == SrcPll && s.m <= 6'd1) c.st = StMSmall;
    else if (s.src == SrcPll && (vco < 64'(VcoMin) || vco > 64'(VcoMax))) c.st = StVcoRange;
    else if (sys > 64'(SysMax)) c.st = StTooFast;
    else c.st = StOk;
    c.vco   = clamp32(vco);
    c.sys   = sys[31:0];
    c.hclk  = clamp32(round_div(sys, ahb_d));
    c.pclk1 = clamp32(round_div(sys, apb1_d));
    c.pclk2 = clamp32(round_div(sys, apb2_d));
    return c;
  endfunction

  // register write, called at a falling edge
  task automatic write_osc(input logic [CfgIdxW-1:0] idx, input logic [OscW-1:0] hz);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = hz;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgIntOsc) begin
      int_osc = hz;
    end else if (idx == CfgExtOsc) begin
      ext_osc = hz;
    end
  endtask

  // offer one request, record its expected clocks once taken
  task automatic send_request(input snap_t s, input logic known, input clocks_t typed_clk);
    int unsigned gap;
    sys_source_i     = s.src;
    ahb_div_code_i   = s.ahb;
    apb1_div_code_i  = s.apb1;
    apb2_div_code_i  = s.apb2;
    pll_input_sel_i  = s.psel;
    pll_mult_n_i     = s.n;
    pll_div_m_i      = s.m;
    pll_div_p_code_i = s.pcode;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_clocks.push_back(known ? typed_clk : calc_clock_tree(s));
    @(negedge clk_i);
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // wait until every request has come back, then let the pipe empty
  task automatic drain_requests();
    in_valid_i = 1'b0;
    wait (pending_clocks.size() == 0);
    repeat (Settle) @(negedge clk_i);
  endtask

  // sender
  initial begin
    snap_t s;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CfgIntOsc;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    sys_source_i     = SrcInt;
    ahb_div_code_i   = '0;
    apb1_div_code_i  = '0;
    apb2_div_code_i  = '0;
    pll_input_sel_i  = 1'b0;
    pll_mult_n_i     = '0;
    pll_div_m_i      = '0;
    pll_div_p_code_i = '0;
    int_osc          = IntOscReset;
    ext_osc          = ExtOscReset;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // writes to unused indexes must leave the oscillators alone
    write_osc(CfgNoReg2, '1);
    write_osc(CfgNoReg3, 26'h2AAAAAA);

    // directed requests
    for (int i = 0; i < NumDirected; i++) begin
      send_request(directed_rows[i].snap, directed_rows[i].known, directed_rows[i].clk);
    end

    // random phases
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_requests();
      if (phase_plan[ph].rnd) begin
        write_osc(CfgIntOsc, OscW'($urandom));
        write_osc(CfgExtOsc, OscW'($urandom));
      end else begin
        write_osc(CfgIntOsc, phase_plan[ph].int_hz);
        write_osc(CfgExtOsc, phase_plan[ph].ext_hz);
      end
      tx_idle_on = phase_plan[ph].tx_idle;
      rx_idle_on = phase_plan[ph].rx_idle;
      for (int k = 0; k < PhaseItems; k++) begin
        if (phase_plan[ph].hold && k == 10) begin
          long_hold = 1'b1;
        end
        if (phase_plan[ph].pause && k == 35) begin
          drain_requests();
        end
        // half plausible pll setups, half anything the fields allow
        if ($urandom_range(0, 1) == 0) begin
          s.src = SrcPll;
          s.n   = 9'($urandom_range(2, 432));
          s.m   = 6'($urandom_range(2, 63));
        end else begin
          s.src = 2'($urandom);
          s.n   = 9'($urandom);
          s.m   = 6'($urandom);
        end
        s.ahb   = 4'($urandom);
        s.apb1  = 3'($urandom);
        s.apb2  = 3'($urandom);
        s.psel  = 1'($urandom);
        s.pcode = 2'($urandom);
        send_request(s, 1'b0, '0);
      end
    end

    in_valid_i = 1'b0;
    wait (pending_clocks.size() == 0);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS clock_tree_frequency_calculator_core");
    end else begin
      $display("FAIL clock_tree_frequency_calculator_core");
    end
    $finish;
  end

  // receiver stalls: a random wait per result, and one long hold-off
  initial begin
    int unsigned wait_cycles;
    logic        hold_done;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        hold_done = 1'b1;
      end
      wait_cycles = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (wait_cycles != 0) begin
        out_stall_i = 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    clocks_t got;
    clocks_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{vco_hz_o, sysclk_hz_o, hclk_hz_o, pclk1_hz_o, pclk2_hz_o,
              flash_wait_states_o, status_e'(status_o)};
      if (pending_clocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: vco %0d sys %0d", got.vco, got.sys);
        end
      end else begin
        want = pending_clocks.pop_front();
        if (got.vco !== want.vco || got.sys !== want.sys || got.hclk !== want.hclk ||
            got.pclk1 !== want.pclk1 || got.pclk2 !== want.pclk2 ||
            got.ws !== want.ws || got.st !== want.st) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp/act: vco %0d/%0d sys %0d/%0d hclk %0d/%0d",
                     want.vco, got.vco, want.sys, got.sys, want.hclk, got.hclk);
            $display("  pclk1 %0d/%0d pclk2 %0d/%0d ws %0d/%0d status %0d/%0d",
                     want.pclk1, got.pclk1, want.pclk2, got.pclk2,
                     want.ws, got.ws, want.st, got.st);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("FAIL clock_tree_frequency_calculator_core");
    $finish;
  end

endmodule

`default_nettype wire
